@@ rtl/prime_factorizer_spf_sieve_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the prime factorizer RTL.
// ----------------------------------------------------------------------------
`ifndef PRIME_FACTORIZER_SPF_SIEVE_DEFINES_SVH
`define PRIME_FACTORIZER_SPF_SIEVE_DEFINES_SVH

// Assertion on an explicit clock and active-low reset.
`define PFS_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the standard clock and reset of the block.
`define PFS_ASSERT(lbl, prop, msg) \
  `PFS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/pfs_pkg.sv @@
// ----------------------------------------------------------------------------
// Prime factorizer package
// Sizes, divider constants and the table port bundle shared by all modules.
// ----------------------------------------------------------------------------
package pfs_pkg;

  localparam int MAX_VALUE  = 4096;
  localparam int IDX_W      = $clog2(MAX_VALUE);
  localparam int VAL_W      = 12;
  localparam int PRIME_W    = 12;
  localparam int EXP_W      = 4;
  localparam int SQ_W       = 2 * IDX_W;
  localparam int DIV_RADIX  = 4;
  localparam int DIV_CYCLES = VAL_W / DIV_RADIX;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [PRIME_W-1:0] wdata;
    logic [IDX_W-1:0]   raddr;
  } pfs_ram_req_t;

endpackage

@@ rtl/pfs_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pfs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/pfs_sieve.sv @@
// ----------------------------------------------------------------------------
// Sieve filler
// Clears the factor table, then marks odd and even composites with their
// smallest prime. Entries left at zero for values two and up are primes.
// ----------------------------------------------------------------------------
module pfs_sieve
  import pfs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [PRIME_W-1:0] rdata_i,
  output pfs_ram_req_t       req_o,
  output logic               done_o
);

  typedef enum logic [5:0] {
    SV_CLEAR  = 6'b000001,
    SV_CHK_RD = 6'b000010,
    SV_CHK_WT = 6'b000100,
    SV_MARK   = 6'b001000,
    SV_DRAIN  = 6'b010000,
    SV_DONE   = 6'b100000
  } sv_state_e;

  sv_state_e        state_q, state_d;
  logic [IDX_W-1:0] clr_q, clr_d;
  logic [IDX_W-1:0] i_q, i_d;
  logic [IDX_W:0]   j_q, j_d;
  logic             pend_q, pend_d;
  logic [IDX_W-1:0] pend_addr_q, pend_addr_d;
  logic [SQ_W-1:0]  sq;
  logic [IDX_W:0]   j_next;

  assign sq     = SQ_W'(i_q) * SQ_W'(i_q);
  assign j_next = j_q + {1'b0, i_q};

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    i_d         = i_q;
    j_d         = j_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    req_o.raddr = i_q;
    case (state_q)
      SV_CLEAR: begin
        clr_d = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(MAX_VALUE - 1)) begin
          state_d = SV_CHK_RD;
        end
      end
      SV_CHK_RD: begin
        if (sq >= SQ_W'(MAX_VALUE)) begin
          state_d = SV_DONE;
        end else begin
          state_d = SV_CHK_WT;
        end
      end
      SV_CHK_WT: begin
        if (rdata_i == '0) begin
          j_d     = (IDX_W + 1)'(sq);
          state_d = SV_MARK;
        end else begin
          i_d     = i_q + IDX_W'(1);
          state_d = SV_CHK_RD;
        end
      end
      SV_MARK: begin
        req_o.raddr = j_q[IDX_W-1:0];
        pend_d      = 1'b1;
        pend_addr_d = j_q[IDX_W-1:0];
        j_d         = j_next;
        if (j_next >= (IDX_W + 1)'(MAX_VALUE)) begin
          state_d = SV_DRAIN;
        end
      end
      SV_DRAIN: begin
        i_d     = i_q + IDX_W'(1);
        state_d = SV_CHK_RD;
      end
      SV_DONE: begin
        state_d = SV_DONE;
      end
      default: begin
        state_d = SV_CLEAR;
      end
    endcase

    if (state_q == SV_CLEAR) begin
      req_o.we    = 1'b1;
      req_o.waddr = clr_q;
      req_o.wdata = '0;
    end else begin
      req_o.we    = pend_q && (rdata_i == '0);
      req_o.waddr = pend_addr_q;
      req_o.wdata = PRIME_W'(i_q);
    end
  end

  assign done_o = (state_q == SV_DONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SV_CLEAR;
      clr_q   <= '0;
      i_q     <= IDX_W'(2);
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      i_q     <= i_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q         <= j_d;
    pend_addr_q <= pend_addr_d;
  end

endmodule

@@ rtl/pfs_div.sv @@
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring division that retires several quotient bits per cycle.
// ----------------------------------------------------------------------------
module pfs_div
  import pfs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [VAL_W-1:0]   dividend_i,
  input  logic [PRIME_W-1:0] divisor_i,
  output logic               done_o,
  output logic [VAL_W-1:0]   quotient_o
);

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [PRIME_W-1:0]   rem_q, rem_d;
  logic [VAL_W-1:0]     quo_q, quo_d;
  logic [PRIME_W-1:0]   div_q, div_d;

  always_comb begin
    logic [PRIME_W:0]   trial;
    logic [PRIME_W-1:0] rem;
    logic [VAL_W-1:0]   quo;
    rem    = rem_q;
    quo    = quo_q;
    trial  = '0;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    div_d  = div_q;
    for (int k = 0; k < DIV_RADIX; k++) begin
      trial = {rem, quo[VAL_W-1]};
      quo   = {quo[VAL_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        trial  = trial - {1'b0, div_q};
        quo[0] = 1'b1;
      end
      rem = trial[PRIME_W-1:0];
    end
    rem_d = rem_q;
    quo_d = quo_q;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      div_d = divisor_i;
      cnt_d = DIV_CNT_W'(DIV_CYCLES);
    end else if (cnt_q != '0) begin
      rem_d  = rem;
      quo_d  = quo;
      cnt_d  = cnt_q - DIV_CNT_W'(1);
      done_d = (cnt_q == DIV_CNT_W'(1));
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

endmodule

@@ rtl/prime_factorizer_spf_sieve.sv @@
// ----------------------------------------------------------------------------
// Prime factorizer with smallest-prime-factor table
// Factors each input value through a sieve-filled table and a divider and
// streams one transaction per distinct prime with its exponent.
// ----------------------------------------------------------------------------
// For each prime factor, counted with multiplicity (up to 11), the block does a
// table read, a step and a division, and it can stall on the output. Values below
// two are accepted and give no results. A new value is accepted only after the
// previous one has been fully factored. After reset the table is cleared and then
// sieved; s_axis_tready_o stays low until the sieve has finished.
`include "prime_factorizer_spf_sieve_defines.svh"

module prime_factorizer_spf_sieve
  import pfs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [11:0] value
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [11:0] prime, [15:12] exponent
  output logic        m_axis_tlast_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RD   = 5'b00010,
    ST_STEP = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } fac_state_e;

  fac_state_e         state_q, state_d;
  logic [VAL_W-1:0]   v_q, v_d;
  logic [PRIME_W-1:0] p_q, p_d;
  logic [PRIME_W-1:0] cur_q, cur_d;
  logic [EXP_W-1:0]   cnt_q, cnt_d;
  logic               m_valid_q, m_valid_d;
  logic [PRIME_W-1:0] m_prime_q, m_prime_d;
  logic [EXP_W-1:0]   m_exp_q, m_exp_d;
  logic               m_last_q, m_last_d;

  pfs_ram_req_t       sieve_req;
  logic               fill_done;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [PRIME_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [PRIME_W-1:0] ram_rdata;

  logic               div_start;
  logic               div_done;
  logic [VAL_W-1:0]   div_quo;

  logic [VAL_W-1:0]   in_value;
  logic               s_fire;
  logic               slot_free;
  logic               need_emit;

  assign in_value  = s_axis_tdata_i[VAL_W-1:0];
  assign s_fire    = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free = !m_valid_q || m_axis_tready_i;
  assign need_emit = (cnt_q != '0) && (p_q != cur_q);

  assign s_axis_tready_o = fill_done && (state_q == ST_IDLE);

  pfs_sieve u_sieve (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rdata_i (ram_rdata),
    .req_o   (sieve_req),
    .done_o  (fill_done)
  );

  assign ram_we    = sieve_req.we && !fill_done;
  assign ram_waddr = sieve_req.waddr;
  assign ram_wdata = sieve_req.wdata;

  always_comb begin
    if (!fill_done) begin
      ram_raddr = sieve_req.raddr;
    end else if (state_q == ST_DIV) begin
      ram_raddr = IDX_W'(div_quo);
    end else begin
      ram_raddr = IDX_W'(in_value);
    end
  end

  pfs_ram #(
    .Width (PRIME_W),
    .Depth (MAX_VALUE)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pfs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (v_q),
    .divisor_i  (p_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d   = state_q;
    v_d       = v_q;
    p_d       = p_q;
    cur_d     = cur_q;
    cnt_d     = cnt_q;
    div_start = 1'b0;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_prime_d = m_prime_q;
    m_exp_d   = m_exp_q;
    m_last_d  = m_last_q;
    case (state_q)
      ST_IDLE: begin
        if (s_fire && (in_value >= VAL_W'(2))
            && (32'(in_value) < 32'(MAX_VALUE))) begin
          v_d     = in_value;
          cnt_d   = '0;
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        if (ram_rdata == '0) begin
          p_d = PRIME_W'(v_q);
        end else begin
          p_d = ram_rdata;
        end
        state_d = ST_STEP;
      end
      ST_STEP: begin
        if (!need_emit || slot_free) begin
          if (need_emit) begin
            m_valid_d = 1'b1;
            m_prime_d = cur_q;
            m_exp_d   = cnt_q;
            m_last_d  = 1'b0;
            cnt_d     = EXP_W'(1);
          end else begin
            cnt_d = cnt_q + EXP_W'(1);
          end
          cur_d     = p_q;
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          v_d = div_quo;
          if (div_quo == VAL_W'(1)) begin
            state_d = ST_FIN;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          m_valid_d = 1'b1;
          m_prime_d = cur_q;
          m_exp_d   = cnt_q;
          m_last_d  = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q       <= v_d;
    p_q       <= p_d;
    cur_q     <= cur_d;
    cnt_q     <= cnt_d;
    m_prime_q <= m_prime_d;
    m_exp_q   <= m_exp_d;
    m_last_q  <= m_last_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {m_exp_q, m_prime_q};
  assign m_axis_tlast_o  = m_last_q;

  `PFS_ASSERT(a_ready_after_fill, s_axis_tready_o |-> fill_done, "input ready before sieve done")
  `PFS_ASSERT(a_no_fill_write_late, fill_done |-> !ram_we, "table written after sieve done")
  `PFS_ASSERT(a_div_nonzero, div_start |-> (p_q >= PRIME_W'(2)), "division by a non-prime")
  `PFS_ASSERT(a_out_exp_nonzero, m_axis_tvalid_o |-> (m_exp_q != '0), "result with zero exponent")
  `PFS_ASSERT(a_div_only_in_step, div_start |-> (state_q == ST_STEP), "divider started out of step")

endmodule
